@@ hw/rtl/tmhs_pkg.sv @@
// Shared types, widths and codes of the timer min-heap scheduler.
`default_nettype none
package tmhs_pkg;

  localparam int CAPACITY_DEF = 64;

  // field widths
  localparam int MODE_W  = 2;
  localparam int TIME_W  = 48;
  localparam int DELAY_W = 32;
  localparam int HNDL_W  = 7;
  localparam int TAG_W   = 32;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 6;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 96;

  localparam logic [CNT_W-1:0] MAX_PER_POLL_RST = 6'd16;

  // input modes
  localparam logic [MODE_W-1:0] MODE_SCHED  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POLL   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RSVD   = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SCHED   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_INACTIVE = 2'd2;

  // one result item
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [HNDL_W-1:0] timer_handle;
    logic [TAG_W-1:0]  user_tag;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  expired_count;
    logic [TIME_W-1:0] until_next;
    logic              none_pending;
    logic              last;
  } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/timer_min_heap_scheduler_unit.sv @@
// Schedule and cancel move the entry by L heap levels, at most log2(CAPACITY); a poll removes
// each expired timer from the heap in the same way and ends with a summary result.
// One transaction at a time; the next input is taken once all results are in the output register.
// Reset (rst, synchronous): empty heap, free handle list 1, 2, 3, ..., max_per_poll = 16.
// Heap and tag memories need no clearing; the handle table resets through per-entry valid bits.
`default_nettype none
module timer_min_heap_scheduler_unit #(
  parameter int CAPACITY = tmhs_pkg::CAPACITY_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // now_time[47:0], delay[79:48], handle[86:80], tag[118:87], zero[119]
  input  wire logic [tmhs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // mode[1:0]
  input  wire logic [tmhs_pkg::MODE_W-1:0]     s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // timer_handle[6:0], user_tag[38:7], status[40:39], expired_count[46:41],
  // until_next[94:47], none_pending[95]
  output logic [tmhs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // kind[1:0]
  output logic [tmhs_pkg::KIND_W-1:0]          m_axis_tuser,
  output logic                                 m_axis_tlast,
  input  wire logic                            cfg_wr_en,
  input  wire logic [tmhs_pkg::CNT_W-1:0]      cfg_wr_data
);
  import tmhs_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int HW     = $clog2(CAPACITY + 2);
  localparam int LIVE_W = $clog2(CAPACITY + 1);
  localparam int NH     = CAPACITY + 1;

  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [HW-1:0]     owner;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCH1, S_UP, S_PLACE, S_CAN1, S_REM, S_REM2, S_DOWN,
    S_PTOP, S_PCHK, S_PEXP, S_EMIT
  } state_t;

  // memories
  rec_t              heap_mem [CAPACITY];
  logic [HW-1:0]     sonf_mem [NH];
  logic [TAG_W-1:0]  tag_mem  [NH];
  logic [NH-1:0]     sonf_vld;
  logic [NH-1:0]     live_bit;

  // memory ports
  logic [SLOT_W-1:0] heap_ra0, heap_ra1, heap_wa;
  rec_t              heap_rd0, heap_rd1, heap_wd;
  logic              heap_we;
  logic [HW-1:0]     sonf_ra, sonf_ra_q, sonf_wa, sonf_wd, sonf_rd;
  logic              sonf_we, sonf_vld_q;
  logic [HW-1:0]     tag_ra, tag_wa;
  logic [TAG_W-1:0]  tag_wd, tag_rd;
  logic              tag_we;

  // control registers
  state_t            state, ret;
  logic [MODE_W-1:0] op;
  logic [TIME_W-1:0] now_q;
  logic [HNDL_W-1:0] hin_q;
  logic [HW-1:0]     free_head, cur_h, rem_h;
  logic [TIME_W-1:0] cur_e;
  logic [SLOT_W-1:0] slot;
  logic [LIVE_W-1:0] live;
  logic [CNT_W-1:0]  n_exp, max_per_poll;
  result_t           res, out_q;
  logic              out_valid;

  // input fields
  logic [TIME_W-1:0]  in_now;
  logic [DELAY_W-1:0] in_delay;
  logic [HNDL_W-1:0]  in_handle;
  logic [TAG_W-1:0]   in_tag;
  assign in_now    = s_axis_tdata[47:0];
  assign in_delay  = s_axis_tdata[79:48];
  assign in_handle = s_axis_tdata[86:80];
  assign in_tag    = s_axis_tdata[118:87];

  // derived values
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] sat_e;
  logic              sched_full, cancel_ok;
  logic [HW-1:0]     sonf_val;
  logic [SLOT_W-1:0] par_slot, par_live, live_m1;
  logic [SLOT_W:0]   child;
  logic              c1ok, pick1, up_swap, dn_swap, rem_go, rem_up, expire;
  rec_t              pick;
  logic [SLOT_W-1:0] pidx;
  logic [SLOT_W:0]   nchild;
  logic [TIME_W-1:0] gap;
  result_t           reply;

  // pack one result
  function automatic result_t make_res(input logic [KIND_W-1:0] k,
                                       input logic [HNDL_W-1:0] h,
                                       input logic [TAG_W-1:0]  t,
                                       input logic [STAT_W-1:0] s,
                                       input logic [CNT_W-1:0]  n,
                                       input logic [TIME_W-1:0] nd,
                                       input logic              np,
                                       input logic              l);
    result_t r;
    r.kind          = k;
    r.timer_handle  = h;
    r.user_tag      = t;
    r.status        = s;
    r.expired_count = n;
    r.until_next    = nd;
    r.none_pending  = np;
    r.last          = l;
    return r;
  endfunction

  assign sum   = {1'b0, in_now} + {{(TIME_W + 1 - DELAY_W){1'b0}}, in_delay};
  assign sat_e = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  assign sched_full = (32'(live) >= CAPACITY) || (free_head == '0) ||
                      (32'(free_head) > CAPACITY);
  assign cancel_ok = (in_handle != '0) && (32'(in_handle) <= CAPACITY) &&
                     live_bit[HW'(in_handle)];
  // entries never written still hold the reset chain i -> i+1
  assign sonf_val  = sonf_vld_q ? sonf_rd : sonf_ra_q + HW'(1);

  assign par_slot = (slot == '0) ? '0 : (slot - SLOT_W'(1)) >> 1;
  assign live_m1  = SLOT_W'(live - LIVE_W'(1));
  assign par_live = (SLOT_W'(live) - SLOT_W'(1)) >> 1;
  assign child    = {slot, 1'b1};
  assign c1ok     = (32'(child) + 1) < 32'(live);
  assign pick1    = c1ok && (heap_rd1.expiry < heap_rd0.expiry);
  assign pick     = pick1 ? heap_rd1 : heap_rd0;
  assign pidx     = pick1 ? SLOT_W'(child + (SLOT_W + 1)'(1)) : SLOT_W'(child);
  assign nchild   = {pidx, 1'b1};
  assign up_swap  = cur_e < heap_rd0.expiry;
  assign dn_swap  = pick.expiry < cur_e;
  assign rem_go   = 32'(slot) < 32'(live) - 1;
  assign rem_up   = (slot != '0) && (heap_rd0.expiry < heap_rd1.expiry);
  assign expire   = (n_exp < max_per_poll) && (heap_rd0.expiry <= now_q);
  // time to the earliest expiry, clamped at zero
  assign gap      = (heap_rd0.expiry > now_q) ? heap_rd0.expiry - now_q : '0;

  // reply for schedule and cancel
  always_comb begin
    reply = '0;
    reply.last = 1'b1;
    if (op == MODE_SCHED) begin
      reply.kind = KIND_SCHED;
      reply.timer_handle = HNDL_W'(cur_h);
    end else begin
      reply.kind = KIND_CANCEL;
      reply.timer_handle = hin_q;
    end
  end

  // memory access control
  always_comb begin
    heap_ra0 = '0;
    heap_ra1 = '0;
    heap_we  = 1'b0;
    heap_wa  = slot;
    heap_wd  = '0;
    sonf_ra  = '0;
    sonf_we  = 1'b0;
    sonf_wa  = '0;
    sonf_wd  = '0;
    tag_ra   = '0;
    tag_we   = 1'b0;
    tag_wa   = free_head;
    tag_wd   = in_tag;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tuser == MODE_SCHED && !sched_full) begin
          sonf_ra = free_head;
          tag_we  = 1'b1;
        end else if (s_axis_tvalid && s_axis_tuser == MODE_CANCEL) begin
          sonf_ra = HW'(in_handle);
        end
      end
      S_SCH1: heap_ra0 = par_live;
      S_UP: begin
        if (up_swap) begin
          heap_we  = 1'b1;
          heap_wd  = heap_rd0;
          sonf_we  = 1'b1;
          sonf_wa  = heap_rd0.owner;
          sonf_wd  = HW'(slot);
          heap_ra0 = (par_slot == '0) ? '0 : (par_slot - SLOT_W'(1)) >> 1;
        end
      end
      S_PLACE: begin
        heap_we = 1'b1;
        heap_wd = '{expiry: cur_e, owner: cur_h};
        sonf_we = 1'b1;
        sonf_wa = cur_h;
        sonf_wd = HW'(slot);
      end
      S_REM: begin
        sonf_we  = 1'b1;
        sonf_wa  = rem_h;
        sonf_wd  = free_head;
        heap_ra0 = live_m1;
        heap_ra1 = par_slot;
      end
      S_REM2: begin
        if (rem_up) begin
          heap_ra0 = par_slot;
        end else begin
          heap_ra0 = SLOT_W'(child);
          heap_ra1 = SLOT_W'(child + (SLOT_W + 1)'(1));
        end
      end
      S_DOWN: begin
        if (dn_swap) begin
          heap_we  = 1'b1;
          heap_wd  = pick;
          sonf_we  = 1'b1;
          sonf_wa  = pick.owner;
          sonf_wd  = HW'(slot);
          heap_ra0 = SLOT_W'(nchild);
          heap_ra1 = SLOT_W'(nchild + (SLOT_W + 1)'(1));
        end
      end
      S_PTOP: heap_ra0 = '0;
      S_PCHK: tag_ra = heap_rd0.owner;
      S_CAN1, S_PEXP, S_EMIT: ;
      default: ;
    endcase
  end

  // heap memory, two read ports
  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    heap_rd0 <= heap_mem[heap_ra0];
    heap_rd1 <= heap_mem[heap_ra1];
  end

  // handle table: heap slot of a live handle, next free handle otherwise
  always_ff @(posedge clk) begin
    if (sonf_we) sonf_mem[sonf_wa] <= sonf_wd;
    sonf_rd    <= sonf_mem[sonf_ra];
    sonf_ra_q  <= sonf_ra;
    sonf_vld_q <= sonf_vld[sonf_ra];
  end

  // tag memory
  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    tag_rd <= tag_mem[tag_ra];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ret          <= S_IDLE;
      out_valid    <= 1'b0;
      live         <= '0;
      free_head    <= HW'(1);
      live_bit     <= '0;
      sonf_vld     <= '0;
      max_per_poll <= MAX_PER_POLL_RST;
    end else begin
      if (cfg_wr_en) max_per_poll <= cfg_wr_data;
      if (sonf_we) sonf_vld[sonf_wa] <= 1'b1;
      // S_EMIT reloads the output register itself
      if (out_valid && m_axis_tready && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op    <= s_axis_tuser;
            now_q <= in_now;
            hin_q <= in_handle;
            n_exp <= '0;
            if (s_axis_tuser == MODE_SCHED) begin
              if (sched_full) begin
                res   <= make_res(KIND_SCHED, '0, '0, STAT_FULL, '0, '0, 1'b0, 1'b1);
                ret   <= S_IDLE;
                state <= S_EMIT;
              end else begin
                live_bit[free_head] <= 1'b1;
                cur_h <= free_head;
                cur_e <= sat_e;
                state <= S_SCH1;
              end
            end else if (s_axis_tuser == MODE_CANCEL) begin
              if (cancel_ok) begin
                state <= S_CAN1;
              end else begin
                res   <= make_res(KIND_CANCEL, in_handle, '0, STAT_INACTIVE, '0, '0,
                                  1'b0, 1'b1);
                ret   <= S_IDLE;
                state <= S_EMIT;
              end
            end else if (s_axis_tuser == MODE_POLL) begin
              state <= S_PTOP;
            end
          end
        end
        S_SCH1: begin
          free_head <= sonf_val;
          slot      <= SLOT_W'(live);
          live      <= live + LIVE_W'(1);
          state     <= (live == '0) ? S_PLACE : S_UP;
        end
        S_UP: begin
          if (up_swap) begin
            slot <= par_slot;
            if (par_slot == '0) state <= S_PLACE;
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE, S_REM: begin
          if (state == S_REM) begin
            live_bit[rem_h] <= 1'b0;
            free_head       <= rem_h;
            live            <= live - LIVE_W'(1);
          end
          if (state == S_REM && rem_go) begin
            state <= S_REM2;
          end else if (op == MODE_POLL) begin
            state <= S_PTOP;
          end else begin
            res   <= reply;
            ret   <= S_IDLE;
            state <= S_EMIT;
          end
        end
        S_CAN1: begin
          slot  <= SLOT_W'(sonf_val);
          rem_h <= HW'(hin_q);
          state <= S_REM;
        end
        S_REM2: begin
          cur_e <= heap_rd0.expiry;
          cur_h <= heap_rd0.owner;
          if (rem_up) state <= S_UP;
          else if (32'(child) < 32'(live)) state <= S_DOWN;
          else state <= S_PLACE;
        end
        S_DOWN: begin
          if (dn_swap) begin
            slot <= pidx;
            if (32'(nchild) >= 32'(live)) state <= S_PLACE;
          end else begin
            state <= S_PLACE;
          end
        end
        S_PTOP: begin
          if (live == '0) begin
            res   <= make_res(KIND_SUMMARY, '0, '0, STAT_OK, n_exp, '0, 1'b1, 1'b1);
            ret   <= S_IDLE;
            state <= S_EMIT;
          end else begin
            state <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (expire) begin
            rem_h <= heap_rd0.owner;
            slot  <= '0;
            state <= S_PEXP;
          end else begin
            res   <= make_res(KIND_SUMMARY, '0, '0, STAT_OK, n_exp, gap, 1'b0, 1'b1);
            ret   <= S_IDLE;
            state <= S_EMIT;
          end
        end
        S_PEXP: begin
          res   <= make_res(KIND_EXPIRED, HNDL_W'(rem_h), tag_rd, STAT_OK, '0, '0,
                            1'b0, 1'b0);
          n_exp <= n_exp + CNT_W'(1);
          ret   <= S_REM;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || m_axis_tready) begin
            out_q     <= res;
            out_valid <= 1'b1;
            state     <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {out_q.none_pending, out_q.until_next, out_q.expired_count,
                          out_q.status, out_q.user_tag, out_q.timer_handle};

endmodule
`default_nettype wire

@@ hw/rtl/tmhs_checker.sv @@
// Port-level checks of the timer min-heap scheduler, bound to the top level.
`default_nettype none
module tmhs_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [tmhs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input wire logic [tmhs_pkg::KIND_W-1:0]       m_axis_tuser,
  input wire logic                              m_axis_tlast
);
  import tmhs_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // output register empties on reset
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // only expired timers continue a transaction
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast != (m_axis_tuser == KIND_EXPIRED)))
    else $error("last flag does not match kind");

  // expired and summary results always carry ok status
  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_EXPIRED || m_axis_tuser == KIND_SUMMARY)
    |-> m_axis_tdata[40:39] == STAT_OK)
    else $error("status set on poll result");

endmodule

bind timer_min_heap_scheduler_unit tmhs_checker u_tmhs_checker (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
